### hdl/windowed_top_n_peak_picker_macros.svh
// Assertion macros for the windowed top-N peak picker.
// Included by the modules that check their own logic; needs clk and arst_n in scope.
`ifndef WINDOWED_TOP_N_PEAK_PICKER_MACROS_SVH
`define WINDOWED_TOP_N_PEAK_PICKER_MACROS_SVH

// property holds on every clock edge outside reset
`define TNPP_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TNPP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/tnpp_pkg.sv
// Shared types and constants of the windowed top-N peak picker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tnpp_pkg;

	localparam int INTEN_W    = 32;
	localparam int MPW_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FL_RD,
		B_FL_OUT,
		B_INSERT,
		B_SC_RD,
		B_SC_CMP,
		B_DECIDE,
		B_SH_RD,
		B_SH_WR,
		B_POST,
		B_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		NX_INSERT,
		NX_EMIT,
		NX_IDLE
	} flush_next_t;

	typedef struct packed {
		logic pass;
		logic last;
	} item_flags_t;

endpackage

`default_nettype wire

### hdl/windowed_top_n_peak_picker.sv
// Each peak request passes through the front end, whose restoring divider produces one
// bit of floor(mass / window_size) per cycle (pass-through skips it); the front end takes
// no new request until the last one is pushed. The back end works on its own behind a
// two-entry queue: it reads each flushed peak from the kept-peak memory over its single
// read port, writes a peak in while the window has room, and in a full window finds the
// weakest entry and shifts those behind it. Peaks must arrive in ascending mass order.
// Top level: configuration registers, front end, queue and back end. Depends on tnpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module windowed_top_n_peak_picker
	import tnpp_pkg::*;
#(
	parameter int MAX_KEEP  = 16,
	parameter int MASS_BITS = 40
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [CFG_ADDR_W-1:0]     paddr,
	input  wire logic [CFG_DATA_W-1:0]     pwdata,
	output logic [CFG_DATA_W-1:0]          prdata,
	output logic                           pready,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// mass_in, intensity_in
	input  wire logic [((MASS_BITS + INTEN_W + 7) / 8) * 8 - 1:0] s_tdata,
	input  wire logic                      s_tlast,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// mass_out, intensity_out
	output logic [((MASS_BITS + INTEN_W + 7) / 8) * 8 - 1:0]      m_tdata,
	output logic                           m_tlast
);

	localparam int TDATA_W = ((MASS_BITS + INTEN_W + 7) / 8) * 8;
	localparam int Q_W     = 2 * MASS_BITS + INTEN_W + 2;

	logic [MPW_W-1:0]     mpw_q;
	logic [MASS_BITS-1:0] wsize_q;
	logic                 cfg_wr;
	logic                 pass_mode;

	logic                 q_push, q_full, q_pop, q_empty;
	logic [MASS_BITS-1:0] f_mass, f_win, b_mass, b_win;
	logic [INTEN_W-1:0]   f_inten, b_inten;
	item_flags_t          f_flags, b_flags;
	logic [Q_W-1:0]       q_in, q_out;
	logic [MASS_BITS-1:0] out_mass;
	logic [INTEN_W-1:0]   out_inten;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign prdata    = paddr[3] ? CFG_DATA_W'(wsize_q) : CFG_DATA_W'(mpw_q);
	assign pass_mode = (mpw_q == '0) || (wsize_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpw_q   <= '0;
			wsize_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				wsize_q <= pwdata[MASS_BITS-1:0];
			end else begin
				mpw_q <= pwdata[MPW_W-1:0];
			end
		end
	end

	tnpp_front #(.MASS_BITS(MASS_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_mass     (s_tdata[MASS_BITS-1:0]),
		.in_inten    (s_tdata[MASS_BITS+INTEN_W-1:MASS_BITS]),
		.in_last     (s_tlast),
		.pass_mode   (pass_mode),
		.window_size (wsize_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_mass      (f_mass),
		.q_inten     (f_inten),
		.q_win       (f_win),
		.q_flags     (f_flags)
	);

	assign q_in = {f_flags, f_win, f_inten, f_mass};
	assign {b_flags, b_win, b_inten, b_mass} = q_out;

	tnpp_queue #(.WIDTH(Q_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	tnpp_back #(.MAX_KEEP(MAX_KEEP), .MASS_BITS(MASS_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_per_window (mpw_q),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.q_mass         (b_mass),
		.q_inten        (b_inten),
		.q_win          (b_win),
		.q_flags        (b_flags),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_mass       (out_mass),
		.out_inten      (out_inten),
		.out_last       (m_tlast)
	);

	assign m_tdata = TDATA_W'({out_inten, out_mass});

endmodule

`default_nettype wire

### hdl/tnpp_front.sv
// Front end: takes in peaks and computes the window index with a radix-2 divider, unless in pass-through.
// Depends on tnpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tnpp_front
	import tnpp_pkg::*;
#(
	parameter int MASS_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [MASS_BITS-1:0] in_mass,
	input  wire logic [INTEN_W-1:0]   in_inten,
	input  wire logic                 in_last,
	input  wire logic                 pass_mode,
	input  wire logic [MASS_BITS-1:0] window_size,
	input  wire logic                 q_full,
	output logic                      q_push,
	output logic [MASS_BITS-1:0]      q_mass,
	output logic [INTEN_W-1:0]        q_inten,
	output logic [MASS_BITS-1:0]      q_win,
	output item_flags_t               q_flags
);

	localparam int STEP_W = $clog2(MASS_BITS);

	front_state_t           state_q, state_d;
	logic [MASS_BITS-1:0]   mass_q;
	logic [INTEN_W-1:0]     inten_q;
	item_flags_t            flags_q;
	logic [MASS_BITS-1:0]   rem_q;
	logic [MASS_BITS-1:0]   quo_q;
	logic [STEP_W-1:0]      step_q;
	logic [MASS_BITS:0]     trial;
	logic [MASS_BITS:0]     diff;
	logic                   ge;
	logic                   div_done;

	assign trial    = {rem_q, quo_q[MASS_BITS-1]};
	assign ge       = trial >= {1'b0, window_size};
	assign diff     = trial - {1'b0, window_size};
	assign div_done = step_q == STEP_W'(MASS_BITS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					state_d = pass_mode ? F_PUSH : F_DIV;
				end
			end
			F_DIV: begin
				if (div_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == F_IDLE;
		q_push   = (state_q == F_PUSH) && !q_full;
		q_mass   = mass_q;
		q_inten  = inten_q;
		q_flags  = flags_q;
		q_win    = flags_q.pass ? '0 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			mass_q       <= in_mass;
			inten_q      <= in_inten;
			flags_q.pass <= pass_mode;
			flags_q.last <= in_last;
			rem_q        <= '0;
			quo_q        <= in_mass;
			step_q       <= '0;
		end else if (state_q == F_DIV) begin
			rem_q  <= ge ? diff[MASS_BITS-1:0] : trial[MASS_BITS-1:0];
			quo_q  <= {quo_q[MASS_BITS-2:0], ge};
			step_q <= step_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/tnpp_queue.sv
// Two-entry queue between the divider front end and the window back end.
// Depends on tnpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_top_n_peak_picker_macros.svh"

module tnpp_queue
	import tnpp_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`TNPP_ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue push while full")
	`TNPP_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue pop while empty")

endmodule

`default_nettype wire

### hdl/tnpp_back.sv
// Back end: keeps the strongest peaks of the open window in a small memory and emits them.
// Depends on tnpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_top_n_peak_picker_macros.svh"

module tnpp_back
	import tnpp_pkg::*;
#(
	parameter int MAX_KEEP  = 16,
	parameter int MASS_BITS = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [MPW_W-1:0]     max_per_window,
	input  wire logic                 q_empty,
	output logic                      q_pop,
	input  wire logic [MASS_BITS-1:0] q_mass,
	input  wire logic [INTEN_W-1:0]   q_inten,
	input  wire logic [MASS_BITS-1:0] q_win,
	input  wire item_flags_t          q_flags,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [MASS_BITS-1:0]      out_mass,
	output logic [INTEN_W-1:0]        out_inten,
	output logic                      out_last
);

	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int LIM_W = (CNT_W > MPW_W) ? CNT_W : MPW_W;
	localparam int ENT_W = MASS_BITS + INTEN_W;

	back_state_t          state_q, state_d;
	flush_next_t          nxt_q;
	logic                 final_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     weak_idx_q;
	logic [INTEN_W-1:0]   weak_int_q;
	logic [MASS_BITS-1:0] item_mass_q;
	logic [INTEN_W-1:0]   item_inten_q;
	logic [MASS_BITS-1:0] item_win_q;
	item_flags_t          item_flags_q;
	logic [MASS_BITS-1:0] cur_win_q;
	logic                 open_q;
	logic                 out_valid_q;
	logic [MASS_BITS-1:0] out_mass_q;
	logic [INTEN_W-1:0]   out_inten_q;
	logic                 out_last_q;

	logic [ENT_W-1:0]     mem [MAX_KEEP];
	logic [ENT_W-1:0]     rdata_q;
	logic [IDX_W-1:0]     raddr;
	logic                 mem_we;
	logic [IDX_W-1:0]     waddr;
	logic [ENT_W-1:0]     wdata;

	logic [LIM_W-1:0]     mpw_ext;
	logic [LIM_W-1:0]     keep_ext;
	logic [LIM_W-1:0]     cnt_ext;
	logic                 room;
	logic                 at_last;
	logic [CNT_W-1:0]     idx_inc;
	logic                 out_free;
	logic                 load_out;
	logic                 load_from_mem;
	logic                 load_last;
	logic                 change;
	logic [INTEN_W-1:0]   rd_inten;

	assign mpw_ext  = LIM_W'(max_per_window);
	assign keep_ext = LIM_W'(MAX_KEEP);
	assign cnt_ext  = LIM_W'(cnt_q);
	assign room     = cnt_ext < ((mpw_ext > keep_ext) ? keep_ext : mpw_ext);
	assign idx_inc  = idx_q + 1'b1;
	assign at_last  = idx_inc == cnt_q;
	assign out_free = !out_valid_q || out_ready;
	assign change   = open_q && (q_win != cur_win_q);
	assign rd_inten = rdata_q[INTEN_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_flags.pass) begin
						state_d = (cnt_q != '0) ? B_FL_RD : B_EMIT;
					end else begin
						state_d = (change && cnt_q != '0) ? B_FL_RD : B_INSERT;
					end
				end
			end
			B_FL_RD: state_d = B_FL_OUT;
			B_FL_OUT: begin
				if (out_free) begin
					if (!at_last) begin
						state_d = B_FL_RD;
					end else begin
						unique case (nxt_q)
							NX_INSERT: state_d = B_INSERT;
							NX_EMIT:   state_d = B_EMIT;
							default:   state_d = B_IDLE;
						endcase
					end
				end
			end
			B_INSERT: state_d = room ? B_POST : B_SC_RD;
			B_SC_RD:  state_d = B_SC_CMP;
			B_SC_CMP: state_d = at_last ? B_DECIDE : B_SC_RD;
			B_DECIDE: state_d = (item_inten_q > weak_int_q) ? B_SH_RD : B_POST;
			B_SH_RD:  state_d = at_last ? B_POST : B_SH_WR;
			B_SH_WR:  state_d = B_SH_RD;
			B_POST:   state_d = item_flags_q.last ? B_FL_RD : B_IDLE;
			B_EMIT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = (state_q == B_IDLE) && !q_empty;
		load_out      = 1'b0;
		load_from_mem = 1'b0;
		load_last     = 1'b0;
		raddr         = idx_q[IDX_W-1:0];
		mem_we        = 1'b0;
		waddr         = idx_q[IDX_W-1:0];
		wdata         = {item_mass_q, item_inten_q};
		unique case (state_q)
			B_FL_OUT: begin
				load_out      = out_free;
				load_from_mem = 1'b1;
				load_last     = at_last &&
					(final_q || (nxt_q == NX_INSERT && !item_flags_q.last));
			end
			B_EMIT: begin
				load_out  = out_free;
				load_last = 1'b1;
			end
			B_INSERT: begin
				mem_we = room;
				waddr  = cnt_q[IDX_W-1:0];
			end
			B_SH_RD: begin
				raddr  = idx_inc[IDX_W-1:0];
				mem_we = at_last;
			end
			B_SH_WR: begin
				mem_we = 1'b1;
				wdata  = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			nxt_q       <= NX_IDLE;
			final_q     <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			cur_win_q   <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					idx_q   <= '0;
					final_q <= 1'b0;
					if (!q_empty) begin
						if (q_flags.pass) begin
							open_q <= 1'b0;
							nxt_q  <= NX_EMIT;
						end else begin
							nxt_q <= NX_INSERT;
						end
					end
				end
				B_FL_OUT: begin
					if (out_free) begin
						if (at_last) begin
							cnt_q <= '0;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				B_INSERT: begin
					cur_win_q <= item_win_q;
					open_q    <= 1'b1;
					idx_q     <= '0;
					if (room) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_SC_CMP: begin
					if (!at_last) begin
						idx_q <= idx_inc;
					end
				end
				B_DECIDE: idx_q <= weak_idx_q;
				B_SH_WR:  idx_q <= idx_inc;
				B_POST: begin
					idx_q <= '0;
					if (item_flags_q.last) begin
						open_q  <= 1'b0;
						final_q <= 1'b1;
						nxt_q   <= NX_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_mass_q  <= q_mass;
			item_inten_q <= q_inten;
			item_win_q   <= q_win;
			item_flags_q <= q_flags;
		end
		if (state_q == B_SC_CMP && (idx_q == '0 || rd_inten <= weak_int_q)) begin
			weak_idx_q <= idx_q;
			weak_int_q <= rd_inten;
		end
		if (load_out) begin
			out_mass_q  <= load_from_mem ? rdata_q[ENT_W-1:INTEN_W] : item_mass_q;
			out_inten_q <= load_from_mem ? rd_inten : item_inten_q;
			out_last_q  <= load_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign out_valid = out_valid_q;
	assign out_mass  = out_mass_q;
	assign out_inten = out_inten_q;
	assign out_last  = out_last_q;

	`TNPP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(MAX_KEEP), "kept count above capacity")
	`TNPP_ASSERT_IMPL(a_flush_idx, state_q == B_FL_OUT, idx_q < cnt_q, "flush index past count")
	`TNPP_ASSERT_IMPL(a_scan_nonempty, state_q == B_SC_RD || state_q == B_SC_CMP,
		cnt_q != '0, "scan of empty window")

endmodule

`default_nettype wire

### verif/tnpp_checker.sv
// Scoreboard for the windowed top-N peak picker: mirrors the register writes,
// predicts the kept peaks of every accepted request and checks the output stream.
// Depends on nothing but the ports of windowed_top_n_peak_picker.
`timescale 1ns / 1ps

module tnpp_checker #(
	parameter int          KEEP_DEPTH = 16,
	parameter logic [3:0]  ADDR_MPW   = 4'h0,
	parameter logic [3:0]  ADDR_WSIZE = 4'h8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          due_count,
	output int          peaks_taken,
	output int          peaks_emitted
);

	typedef struct {
		logic [39:0] mass;
		logic [31:0] inten;
		logic        run_last;
	} peak_t;

	peak_t       peaks_due[$];
	logic [4:0]  max_per_window;
	logic [39:0] window_size;
	logic [39:0] cur_window;
	logic        window_open;
	logic [39:0] kept_mass [KEEP_DEPTH];
	logic [31:0] kept_inten [KEEP_DEPTH];
	int          kept_count;

	function automatic void emit_peak(logic [39:0] mass, logic [31:0] inten);
		peak_t p;
		p.mass = mass;
		p.inten = inten;
		p.run_last = 1'b0;
		peaks_due.insert(peaks_due.size(), p);
	endfunction

	function automatic void flush_window();
		for (int i = 0; i < kept_count; i++)
			emit_peak(kept_mass[i], kept_inten[i]);
		kept_count = 0;
	endfunction

	function automatic void keep_peak(logic [39:0] mass, logic [31:0] inten);
		int limit;
		int weakest;
		limit = (max_per_window > KEEP_DEPTH) ? KEEP_DEPTH : int'(max_per_window);
		if (kept_count < limit) begin
			kept_mass[kept_count] = mass;
			kept_inten[kept_count] = inten;
			kept_count++;
			return;
		end
		if (kept_count == 0)
			return;
		weakest = 0;
		for (int i = 1; i < kept_count; i++)
			if (kept_inten[i] <= kept_inten[weakest])
				weakest = i;
		if (inten <= kept_inten[weakest])
			return;
		for (int i = weakest; i + 1 < kept_count; i++) begin
			kept_mass[i] = kept_mass[i + 1];
			kept_inten[i] = kept_inten[i + 1];
		end
		kept_mass[kept_count - 1] = mass;
		kept_inten[kept_count - 1] = inten;
	endfunction

	function automatic void pick_peaks(logic [39:0] mass, logic [31:0] inten, logic last);
		int          before_n;
		logic [39:0] w;
		before_n = peaks_due.size();
		if (max_per_window == 0 || window_size == 0) begin
			flush_window();
			emit_peak(mass, inten);
			window_open = 1'b0;
		end else begin
			w = mass / window_size;
			if (window_open && w != cur_window)
				flush_window();
			cur_window = w;
			window_open = 1'b1;
			keep_peak(mass, inten);
			if (last) begin
				flush_window();
				window_open = 1'b0;
			end
		end
		if (peaks_due.size() > before_n)
			peaks_due[peaks_due.size() - 1].run_last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		peak_t e;
		if (!arst_n) begin
			max_per_window <= '0;
			window_size    <= '0;
			cur_window     = '0;
			window_open    = 1'b0;
			kept_count     = 0;
			fail_count     <= 0;
			peaks_taken    <= 0;
			peaks_emitted  <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_MPW)
					max_per_window <= pwdata[4:0];
				else if (paddr == ADDR_WSIZE)
					window_size <= pwdata[39:0];
			end
			if (s_tvalid && s_tready) begin
				pick_peaks(s_tdata[39:0], s_tdata[71:40], s_tlast);
				peaks_taken <= peaks_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				peaks_emitted <= peaks_emitted + 1;
				if (peaks_due.size() == 0) begin
					if (fail_count < 10)
						$display("[%0t] unexpected peak mass=%h inten=%h last=%b",
							$realtime, m_tdata[39:0], m_tdata[71:40], m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					e = peaks_due.pop_front();
					if (e.mass !== m_tdata[39:0] || e.inten !== m_tdata[71:40] ||
							e.run_last !== m_tlast) begin
						if (fail_count < 10)
							$display("[%0t] mismatch exp mass=%h inten=%h last=%b, got mass=%h inten=%h last=%b",
								$realtime, e.mass, e.inten, e.run_last,
								m_tdata[39:0], m_tdata[71:40], m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		due_count <= peaks_due.size();
	end

endmodule

### verif/testbench.sv
// Top of the peak picker testbench: clock, reset, APB setup, peak stimulus and verdict.
// Depends on tnpp_checker and the windowed_top_n_peak_picker RTL.
`timescale 1ns / 1ps

module testbench;

	localparam logic [3:0] ADDR_MPW   = 4'h0;
	localparam logic [3:0] ADDR_WSIZE = 4'h8;
	localparam int         LIMIT      = 1000000;
	localparam int         N_ITEMS    = 370;
	localparam longint unsigned MASS_MAX = 64'hFF_FFFF_FFFF;
	localparam longint unsigned ONE      = 64'h1_0000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready, s_tlast;
	logic [71:0] s_tdata;  // mass_in[39:0], intensity_in[71:40]
	logic        m_tvalid, m_tready, m_tlast;
	logic [71:0] m_tdata;  // mass_out[39:0], intensity_out[71:40]

	int fail_count, due_count, peaks_taken, peaks_emitted;
	int cycles;
	int sent;
	int cfg_writes;
	bit quiet;
	int ready_left;

	windowed_top_n_peak_picker u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	tnpp_checker #(.ADDR_MPW(ADDR_MPW), .ADDR_WSIZE(ADDR_WSIZE)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .due_count(due_count),
		.peaks_taken(peaks_taken), .peaks_emitted(peaks_emitted)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// output stalls: random ready and stall bursts, none once quiet
	always @(negedge clk) begin
		if (ready_left > 0) begin
			ready_left--;
		end else if (quiet || $urandom_range(0, 2) != 0) begin
			m_tready = 1'b1;
			ready_left = $urandom_range(0, 20);
		end else begin
			m_tready = 1'b0;
			ready_left = $urandom_range(0, 10);
		end
	end

	task automatic apb_write(logic [3:0] addr, logic [63:0] data);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// registers change only once no predicted peak is outstanding
	task automatic set_config(logic [4:0] mpw, logic [39:0] wsize);
		s_tvalid = 1'b0;
		while (due_count != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		apb_write(ADDR_MPW, {59'd0, mpw});
		apb_write(ADDR_WSIZE, {24'd0, wsize});
		cfg_writes++;
	endtask

	task automatic send_peak(longint unsigned mass, logic [31:0] inten, logic last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {inten, mass[39:0]};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	function automatic longint unsigned rand_mass();
		return {$urandom, $urandom} & MASS_MAX;
	endfunction

	function automatic logic [31:0] rand_inten();
		return ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
	endfunction

	function automatic longint unsigned rand_wsize();
		case ($urandom_range(0, 4))
			0: return 1;
			1: return MASS_MAX;
			2: return rand_mass();
			default: return longint'($urandom_range(1, 65535)) << $urandom_range(0, 20);
		endcase
	endfunction

	initial begin
		longint unsigned mass, wsize, step;
		int len;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		m_tready = 1'b0;
		quiet = 1'b0;
		ready_left = 0;
		cycles = 0; sent = 0; cfg_writes = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pass through at reset values, field extremes
		send_peak(0, 32'd0, 1'b0);
		send_peak(MASS_MAX, 32'hFFFF_FFFF, 1'b1);

		// two per unit window: ties, replacement, window change, unsorted return
		set_config(5'd2, 40'(ONE));
		send_peak(ONE, 32'd5, 1'b0);
		send_peak(ONE + ONE / 2, 32'd9, 1'b0);
		send_peak(ONE + 45000, 32'd5, 1'b0);
		send_peak(ONE + 50000, 32'd7, 1'b0);
		send_peak(2 * ONE + 9000, 32'd1, 1'b0);
		send_peak(ONE / 2, 32'd3, 1'b0);
		send_peak(ONE - 1, 32'd3, 1'b1);

		// limit lowered while a window is open, then pass through flushes it
		set_config(5'd3, 40'(MASS_MAX));
		send_peak(10, 32'd4, 1'b0);
		send_peak(11, 32'd8, 1'b0);
		send_peak(12, 32'd6, 1'b0);
		set_config(5'd1, 40'(MASS_MAX));
		send_peak(13, 32'd7, 1'b0);
		send_peak(14, 32'd2, 1'b0);
		set_config(5'd0, 40'(MASS_MAX));
		send_peak(15, 32'd1, 1'b0);

		// limit above the store depth, unit window size
		set_config(5'd31, 40'd1);
		send_peak(5, 32'd1, 1'b0);
		send_peak(5, 32'd1, 1'b0);
		send_peak(5, 32'hFFFF_FFFF, 1'b1);

		while (sent < N_ITEMS) begin
			if (sent > N_ITEMS - 50)
				quiet = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				wsize = ($urandom_range(0, 9) == 0) ? 0 : rand_wsize();
				set_config(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(1, 16)), 40'(wsize));
			end else begin
				wsize = 1 + ({$urandom, $urandom} & MASS_MAX) % 1000000;
			end
			len = $urandom_range(1, 24);
			if ($urandom_range(0, 9) == 0) begin
				for (int i = 0; i < len; i++)
					send_peak(rand_mass(), rand_inten(), i == len - 1);
			end else begin
				mass = ($urandom_range(0, 1) == 0) ? rand_mass() : longint'($urandom);
				for (int i = 0; i < len; i++) begin
					step = (wsize == 0) ? $urandom : wsize * $urandom_range(0, 3) / 4;
					mass = (MASS_MAX - mass < step) ? MASS_MAX : mass + step;
					send_peak(mass, rand_inten(), i == len - 1);
				end
			end
		end
		s_tvalid = 1'b0;
		s_tlast = 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		$display("%0d peak requests taken, %0d kept peaks checked, %0d register settings",
			peaks_taken, peaks_emitted, cfg_writes);
		if (fail_count == 0 && due_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d peaks outstanding", fail_count, due_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
